@@ hw/rtl/vgcd_pkg.sv @@
// Shared types and constants for the volume gradient block.
package vgcd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GRAD_W   = 29;
   localparam int SIZE_W   = 6;
   localparam int SCALE_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Operation codes of the request channel.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING = 2'd3;

   localparam logic [SCALE_W-1:0] INV_SPACING_RST = 12'd255;
   localparam int SIZE_RST_NOMINAL = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Control of the shared difference unit.
   typedef struct packed {
      logic load_plus;
      logic compute;
      logic halve;
   } diff_ctl_type;

endpackage

@@ hw/rtl/vgcd_if.sv @@
// Request and response channel interfaces.
interface vgcd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  operation;
   logic signed [vgcd_pkg::SAMPLE_W-1:0]  sample_value;

   modport source (output valid, output operation, output sample_value, input ready);
   modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface vgcd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vgcd_pkg::GRAD_W-1:0]  grad_x;
   logic signed [vgcd_pkg::GRAD_W-1:0]  grad_y;
   logic signed [vgcd_pkg::GRAD_W-1:0]  grad_z;
   logic                                last_point;

   modport source (output valid, output grad_x, output grad_y, output grad_z,
                   output last_point, input ready);
   modport sink   (input valid, input grad_x, input grad_y, input grad_z,
                   input last_point, output ready);
endinterface

@@ hw/rtl/vgcd_ram.sv @@
// Generic single-port RAM with registered read.
module vgcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  addr,
   input  logic [WIDTH-1:0]          wdata,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/vgcd_diff_unit.sv @@
// Shared subtract, scale and halve unit, one gradient component at a time.
module vgcd_diff_unit (
   input  logic                                  clock,
   input  vgcd_pkg::diff_ctl_type                ctl,
   input  logic signed [vgcd_pkg::SAMPLE_W-1:0]  sample,
   input  logic [vgcd_pkg::SCALE_W-1:0]          scale,
   output logic signed [vgcd_pkg::GRAD_W-1:0]    result
);

   localparam int DIFF_W = vgcd_pkg::SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + vgcd_pkg::SCALE_W + 1;

   logic signed [vgcd_pkg::SAMPLE_W-1:0] plus_ff;
   logic signed [vgcd_pkg::GRAD_W-1:0]   result_ff;
   logic signed [vgcd_pkg::GRAD_W-1:0]   result_in;
   logic signed [DIFF_W-1:0]             diff;
   logic signed [PROD_W-1:0]             prod;
   logic signed [PROD_W-1:0]             half;

   always_comb begin
      diff = DIFF_W'(plus_ff) - DIFF_W'(sample);
      prod = PROD_W'(diff) * PROD_W'($signed({1'b0, scale}));
      // floor halving of an inner-point difference
      half = prod >>> 1;
      result_in = ctl.halve ? half[vgcd_pkg::GRAD_W-1:0] : prod[vgcd_pkg::GRAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_plus) begin
         plus_ff <= sample;
      end
      if (ctl.compute) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

@@ hw/rtl/volume_gradient_central_difference.sv @@
// Top level: volume store, raster counters and fetch sequencer.
//
//  channel | dir | payload                                  | transfer when
//  req     | in  | operation, sample_value                  | req.valid & req.ready
//  rsp     | out | grad_x, grad_y, grad_z, last_point       | rsp.valid & rsp.ready
//  csr     | in  | csr_index, csr_data                      | csr_we
//
// A load writes the sample at the load counter's address on its transfer.
// A fetch occupies the sequencer from its transfer until it is back in idle: six
// single-port reads, one per neighbor, feed one shared subtract-scale unit, then the
// read data register and the last product follow. The result is loaded into the
// response register at the end of the fetch, later while the previous result waits.
// Reset clears the counters and sequencer; the volume memory is not cleared.
module volume_gradient_central_difference #(
   parameter int MAX_DIM = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   vgcd_req_if.sink                             req,
   vgcd_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [vgcd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vgcd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_DIM);
   localparam int XW    = ((CW > vgcd_pkg::SIZE_W) ? CW : vgcd_pkg::SIZE_W) + 1;
   localparam logic [vgcd_pkg::SIZE_W-1:0] SIZE_RST =
      vgcd_pkg::SIZE_W'((MAX_DIM < vgcd_pkg::SIZE_RST_NOMINAL) ?
                        MAX_DIM : vgcd_pkg::SIZE_RST_NOMINAL);
   localparam logic [2:0] STEP_LAST = 3'd7;

   function automatic logic [vgcd_pkg::SIZE_W-1:0] clamp_size(
      input logic [vgcd_pkg::SIZE_W-1:0] v);
      logic [vgcd_pkg::SIZE_W-1:0] r;
      r = v;
      if (v < vgcd_pkg::SIZE_W'(2)) begin
         r = vgcd_pkg::SIZE_W'(2);
      end else if (int'(v) > MAX_DIM) begin
         r = vgcd_pkg::SIZE_W'(MAX_DIM);
      end
      return r;
   endfunction

   // Configuration registers
   logic [vgcd_pkg::SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [vgcd_pkg::SCALE_W-1:0] inv_spacing_ff;

   // Raster counters
   logic [CW-1:0] ld_x_ff, ld_y_ff, ld_z_ff;
   logic [CW-1:0] ld_x_in, ld_y_in, ld_z_in;
   logic [AW-1:0] ld_lin_ff, ld_lin_in;
   logic [CW-1:0] ft_x_ff, ft_y_ff, ft_z_ff;
   logic [CW-1:0] ft_x_in, ft_y_in, ft_z_in;
   logic [AW-1:0] ft_lin_ff, ft_lin_in;

   // Sequencer
   vgcd_pkg::state_type state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic [AW-1:0] center_ff;
   logic [2:0]    edge_lo_ff, edge_hi_ff;
   logic          last_ff;
   logic signed [vgcd_pkg::GRAD_W-1:0] gx_ff, gy_ff;

   // Response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [vgcd_pkg::GRAD_W-1:0] rsp_gx_ff, rsp_gy_ff, rsp_gz_ff;
   logic                               rsp_last_ff;

   logic          req_xfer, load_xfer, fetch_xfer;
   logic          slot_free, deliver;
   logic [XW-1:0] sx_m1, sy_m1, sz_m1;
   logic [11:0]   area;
   logic [AW-1:0] stride_x, stride_y, stride, rd_addr;
   logic [1:0]    rd_axis, comp_axis;
   logic          rd_lo, rd_hi, comp_inner;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [vgcd_pkg::SAMPLE_W-1:0] ram_rdata;
   vgcd_pkg::diff_ctl_type dctl;
   logic signed [vgcd_pkg::GRAD_W-1:0] diff_result;

   assign req_xfer   = req.valid && req.ready;
   assign load_xfer  = req_xfer && (req.operation == vgcd_pkg::OP_LOAD);
   assign fetch_xfer = req_xfer && (req.operation == vgcd_pkg::OP_FETCH);
   assign slot_free  = !rsp_valid_ff || rsp.ready;

   assign sx_m1 = XW'(size_x_ff) - XW'(1);
   assign sy_m1 = XW'(size_y_ff) - XW'(1);
   assign sz_m1 = XW'(size_z_ff) - XW'(1);
   assign area     = 12'(size_y_ff) * 12'(size_z_ff);
   assign stride_x = AW'(area);
   assign stride_y = AW'(size_z_ff);

   // Advance load raster position, z innermost
   always_comb begin
      ld_x_in   = ld_x_ff;
      ld_y_in   = ld_y_ff;
      ld_z_in   = ld_z_ff + CW'(1);
      ld_lin_in = ld_lin_ff + AW'(1);
      if (XW'(ld_z_ff) == sz_m1) begin
         ld_z_in = '0;
         ld_y_in = ld_y_ff + CW'(1);
         if (XW'(ld_y_ff) == sy_m1) begin
            ld_y_in = '0;
            ld_x_in = ld_x_ff + CW'(1);
            if (XW'(ld_x_ff) == sx_m1) begin
               ld_x_in   = '0;
               ld_lin_in = '0;
            end
         end
      end
   end

   // Advance fetch raster position
   always_comb begin
      ft_x_in   = ft_x_ff;
      ft_y_in   = ft_y_ff;
      ft_z_in   = ft_z_ff + CW'(1);
      ft_lin_in = ft_lin_ff + AW'(1);
      if (XW'(ft_z_ff) == sz_m1) begin
         ft_z_in = '0;
         ft_y_in = ft_y_ff + CW'(1);
         if (XW'(ft_y_ff) == sy_m1) begin
            ft_y_in = '0;
            ft_x_in = ft_x_ff + CW'(1);
            if (XW'(ft_x_ff) == sx_m1) begin
               ft_x_in   = '0;
               ft_lin_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff      <= SIZE_RST;
         size_y_ff      <= SIZE_RST;
         size_z_ff      <= SIZE_RST;
         inv_spacing_ff <= vgcd_pkg::INV_SPACING_RST;
         ld_x_ff   <= '0;
         ld_y_ff   <= '0;
         ld_z_ff   <= '0;
         ld_lin_ff <= '0;
         ft_x_ff   <= '0;
         ft_y_ff   <= '0;
         ft_z_ff   <= '0;
         ft_lin_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            vgcd_pkg::CSR_SIZE_X: size_x_ff <= clamp_size(csr_data[vgcd_pkg::SIZE_W-1:0]);
            vgcd_pkg::CSR_SIZE_Y: size_y_ff <= clamp_size(csr_data[vgcd_pkg::SIZE_W-1:0]);
            vgcd_pkg::CSR_SIZE_Z: size_z_ff <= clamp_size(csr_data[vgcd_pkg::SIZE_W-1:0]);
            vgcd_pkg::CSR_INV_SPACING: inv_spacing_ff <= csr_data;
            default: inv_spacing_ff <= inv_spacing_ff;
         endcase
         // any register write restarts both rasters
         ld_x_ff   <= '0;
         ld_y_ff   <= '0;
         ld_z_ff   <= '0;
         ld_lin_ff <= '0;
         ft_x_ff   <= '0;
         ft_y_ff   <= '0;
         ft_z_ff   <= '0;
         ft_lin_ff <= '0;
      end else begin
         if (load_xfer) begin
            ld_x_ff   <= ld_x_in;
            ld_y_ff   <= ld_y_in;
            ld_z_ff   <= ld_z_in;
            ld_lin_ff <= ld_lin_in;
         end
         if (fetch_xfer) begin
            ft_x_ff   <= ft_x_in;
            ft_y_ff   <= ft_y_in;
            ft_z_ff   <= ft_z_in;
            ft_lin_ff <= ft_lin_in;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vgcd_pkg::ST_IDLE: begin
            if (fetch_xfer) begin
               state_in = vgcd_pkg::ST_FETCH;
            end
         end
         vgcd_pkg::ST_FETCH: begin
            if (step_ff == STEP_LAST) begin
               state_in = slot_free ? vgcd_pkg::ST_IDLE : vgcd_pkg::ST_DONE;
            end
         end
         vgcd_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = vgcd_pkg::ST_IDLE;
            end
         end
         default: state_in = vgcd_pkg::ST_IDLE;
      endcase
   end

   // Read address for the neighbor pair of the current step
   always_comb begin
      rd_axis = step_ff[2:1];
      case (rd_axis)
         2'd0: begin
            stride = stride_x;
            rd_lo  = edge_lo_ff[0];
            rd_hi  = edge_hi_ff[0];
         end
         2'd1: begin
            stride = stride_y;
            rd_lo  = edge_lo_ff[1];
            rd_hi  = edge_hi_ff[1];
         end
         default: begin
            stride = AW'(1);
            rd_lo  = edge_lo_ff[2];
            rd_hi  = edge_hi_ff[2];
         end
      endcase
      if (!step_ff[0]) begin
         rd_addr = rd_hi ? center_ff : center_ff + stride;
      end else begin
         rd_addr = rd_lo ? center_ff : center_ff - stride;
      end
   end

   // Axis whose minus sample arrives this step
   always_comb begin
      comp_axis = 2'(step_ff[2:1] - 2'd1);
      case (comp_axis)
         2'd0:    comp_inner = !edge_lo_ff[0] && !edge_hi_ff[0];
         2'd1:    comp_inner = !edge_lo_ff[1] && !edge_hi_ff[1];
         default: comp_inner = !edge_lo_ff[2] && !edge_hi_ff[2];
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req.ready      = 1'b0;
      ram_we         = 1'b0;
      ram_addr       = ld_lin_ff;
      dctl.load_plus = 1'b0;
      dctl.compute   = 1'b0;
      dctl.halve     = comp_inner;
      deliver        = 1'b0;
      step_in        = step_ff;
      case (state_ff)
         vgcd_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            ram_we    = load_xfer;
            step_in   = '0;
         end
         vgcd_pkg::ST_FETCH: begin
            ram_addr       = rd_addr;
            // odd steps bring a plus sample, even steps the matching minus sample
            dctl.load_plus = step_ff[0] && (step_ff != STEP_LAST);
            dctl.compute   = !step_ff[0] && (step_ff != 3'd0);
            deliver        = (step_ff == STEP_LAST) && slot_free;
            step_in        = step_ff + 3'd1;
         end
         vgcd_pkg::ST_DONE: begin
            deliver = slot_free;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vgcd_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Fetch context, captured at the fetch transfer, and the x and y gradients held for the response
   always_ff @(posedge clock) begin
      if (fetch_xfer) begin
         center_ff  <= ft_lin_ff;
         edge_lo_ff <= {ft_z_ff == '0, ft_y_ff == '0, ft_x_ff == '0};
         edge_hi_ff <= {XW'(ft_z_ff) == sz_m1, XW'(ft_y_ff) == sy_m1,
                        XW'(ft_x_ff) == sx_m1};
         last_ff    <= (XW'(ft_x_ff) == sx_m1) && (XW'(ft_y_ff) == sy_m1) &&
                       (XW'(ft_z_ff) == sz_m1);
      end
      if (state_ff == vgcd_pkg::ST_FETCH && step_ff == 3'd3) begin
         gx_ff <= diff_result;
      end
      if (state_ff == vgcd_pkg::ST_FETCH && step_ff == 3'd5) begin
         gy_ff <= diff_result;
      end
   end

   assign rsp_valid_in = deliver ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (deliver) begin
         rsp_gx_ff   <= gx_ff;
         rsp_gy_ff   <= gy_ff;
         rsp_gz_ff   <= diff_result;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.grad_x     = rsp_gx_ff;
   assign rsp.grad_y     = rsp_gy_ff;
   assign rsp.grad_z     = rsp_gz_ff;
   assign rsp.last_point = rsp_last_ff;

   vgcd_ram #(
      .WIDTH (vgcd_pkg::SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_volume (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req.sample_value),
      .rdata (ram_rdata)
   );

   vgcd_diff_unit u_diff (
      .clock  (clock),
      .ctl    (dctl),
      .sample ($signed(ram_rdata)),
      .scale  (inv_spacing_ff),
      .result (diff_result)
   );

endmodule

@@ hw/rtl/vgcd_checker.sv @@
// Port-level checks for the volume gradient block, bound to the top level.
module vgcd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_operation,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [vgcd_pkg::GRAD_W-1:0]  rsp_grad_x,
   input logic                                rsp_last_point
);

   // Hold a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grad_x) && $stable(rsp_last_point))
      else $error("stalled response changed");

   // Come out of reset idle and empty.
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // A fetch transfer occupies the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == vgcd_pkg::OP_FETCH) |=> !req_ready)
      else $error("ready right after a fetch");

   // A load transfer leaves the block ready for the next request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == vgcd_pkg::OP_LOAD) |=> req_ready)
      else $error("not ready after a load");

endmodule

bind volume_gradient_central_difference vgcd_checker u_vgcd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_operation  (req.operation),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_grad_x     (rsp.grad_x),
   .rsp_last_point (rsp.last_point)
);
